// ----- hw/rtl/bbcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcs_pkg
// Shared types and constants for the bounding box center and scale block.
// ----------------------------------------------------------------------------
package bbcs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int EXT_OUT_W   = 20;
  localparam int SCALE_W     = 32;
  localparam int STATUS_W    = 2;

  // extent sum of three axes, nine times an extent, divider dividend
  localparam int SUM_W    = COORD_WIDTH + 2;
  localparam int NINE_W   = COORD_WIDTH + 4;
  localparam int NUM_W    = NINE_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_POINTS   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_EXTENT = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [EXT_OUT_W-1:0]   scaled_extent_x;
    logic        [EXT_OUT_W-1:0]   scaled_extent_y;
    logic        [EXT_OUT_W-1:0]   scaled_extent_z;
    logic        [SCALE_W-1:0]     scale_factor;
    logic        [STATUS_W-1:0]    status;
  } result_t;

  typedef enum logic [1:0] {
    OP_EXT_X,
    OP_EXT_Y,
    OP_EXT_Z,
    OP_SCALE
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXTENT,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    acc_point;
    logic    cap_extent;
    logic    cap_sum;
    logic    div_load;
    logic    div_store;
    div_op_t op;
    logic    clear;
  } bbcs_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } bbcs_sts_t;

endpackage

// ----- hw/rtl/bbcs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcs_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module bbcs_div
  import bbcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] divisor;
  logic [NUM_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem, shreg[NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // dividend bits shift out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        cnt     <= CNT_W'(DIV_STEPS);
        rem     <= '0;
        shreg   <= num;
        divisor <= den;
      end else if (cnt != '0) begin
        cnt   <= cnt - 1'b1;
        rem   <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        shreg <= {shreg[NUM_W-2:0], fits};
        done  <= (cnt == CNT_W'(1));
      end
    end
  end

  assign quo = shreg;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/bbcs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcs_dp
// Datapath: running box, extents, centers and the shared divider.
// ----------------------------------------------------------------------------
module bbcs_dp
  import bbcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  point_t    point,
  input  bbcs_cmd_t cmd,
  output bbcs_sts_t sts,
  output result_t   result
);

  logic signed [COORD_WIDTH-1:0] min_x, min_y, min_z;
  logic signed [COORD_WIDTH-1:0] max_x, max_y, max_z;
  logic                          any_point_seen;
  logic [COORD_WIDTH-1:0]        ext_x, ext_y, ext_z;
  logic [SUM_W-1:0]              sum;
  logic [COORD_WIDTH:0]          diff_x, diff_y, diff_z;
  logic [COORD_WIDTH-1:0]        ext_sel;
  logic [NINE_W-1:0]             nine_ext;
  logic [NUM_W-1:0]              div_num;
  logic [NUM_W-1:0]              quo;
  logic                          div_done;

  // max >= min whenever a point was seen, so the difference fits unsigned
  always_comb begin
    diff_x = {max_x[COORD_WIDTH-1], max_x} - {min_x[COORD_WIDTH-1], min_x};
    diff_y = {max_y[COORD_WIDTH-1], max_y} - {min_y[COORD_WIDTH-1], min_y};
    diff_z = {max_z[COORD_WIDTH-1], max_z} - {min_z[COORD_WIDTH-1], min_z};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      min_x <= COORD_MAX;
      min_y <= COORD_MAX;
      min_z <= COORD_MAX;
      max_x <= COORD_MIN;
      max_y <= COORD_MIN;
      max_z <= COORD_MIN;
      any_point_seen <= 1'b0;
    end else if (cmd.acc_point) begin
      if (point.point_x < min_x) min_x <= point.point_x;
      if (point.point_y < min_y) min_y <= point.point_y;
      if (point.point_z < min_z) min_z <= point.point_z;
      if (point.point_x > max_x) max_x <= point.point_x;
      if (point.point_y > max_y) max_y <= point.point_y;
      if (point.point_z > max_z) max_z <= point.point_z;
      any_point_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_extent) begin
      ext_x <= diff_x[COORD_WIDTH-1:0];
      ext_y <= diff_y[COORD_WIDTH-1:0];
      ext_z <= diff_z[COORD_WIDTH-1:0];
      if (any_point_seen) begin
        result.center_x <= min_x + $signed({1'b0, diff_x[COORD_WIDTH-1:1]});
        result.center_y <= min_y + $signed({1'b0, diff_y[COORD_WIDTH-1:1]});
        result.center_z <= min_z + $signed({1'b0, diff_z[COORD_WIDTH-1:1]});
      end else begin
        result.center_x <= '0;
        result.center_y <= '0;
        result.center_z <= '0;
      end
    end
    if (cmd.cap_sum) begin
      sum <= SUM_W'(ext_x) + SUM_W'(ext_y) + SUM_W'(ext_z);
      // defaults for the cases that skip the division
      result.scaled_extent_x <= '0;
      result.scaled_extent_y <= '0;
      result.scaled_extent_z <= '0;
      result.scale_factor    <= '1;
      if (!any_point_seen) begin
        result.status <= STATUS_NO_POINTS;
      end else if ((ext_x | ext_y | ext_z) == '0) begin
        result.status <= STATUS_ZERO_EXTENT;
      end else begin
        result.status <= STATUS_OK;
      end
    end
    if (cmd.div_store) begin
      unique case (cmd.op)
        OP_EXT_X: result.scaled_extent_x <= quo[EXT_OUT_W-1:0];
        OP_EXT_Y: result.scaled_extent_y <= quo[EXT_OUT_W-1:0];
        OP_EXT_Z: result.scaled_extent_z <= quo[EXT_OUT_W-1:0];
        OP_SCALE: result.scale_factor <=
                    (quo[NUM_W-1:SCALE_W] != '0) ? '1 : quo[SCALE_W-1:0];
        default:  result.scale_factor <= result.scale_factor;
      endcase
    end
  end

  // dividend: 9 * extent with the fraction shift, or 9 with a double shift
  always_comb begin
    case (cmd.op)
      OP_EXT_X: ext_sel = ext_x;
      OP_EXT_Y: ext_sel = ext_y;
      default:  ext_sel = ext_z;
    endcase
    nine_ext = NINE_W'({ext_sel, 3'b000}) + NINE_W'(ext_sel);
    if (cmd.op == OP_SCALE) begin
      div_num = NUM_W'(9) << (2 * FRAC_BITS);
    end else begin
      div_num = {nine_ext, {FRAC_BITS{1'b0}}};
    end
  end

  bbcs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.div_load),
    .num  (div_num),
    .den  (sum),
    .quo  (quo),
    .done (div_done)
  );

  assign sts.need_div = (result.status == STATUS_OK);
  assign sts.div_done = div_done;

endmodule

// ----- hw/rtl/bbcs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcs_ctrl
// Controller: point intake, result sequencing and divider scheduling.
// ----------------------------------------------------------------------------
module bbcs_ctrl
  import bbcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      last_point,
  input  bbcs_sts_t sts,
  output bbcs_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  state_t  state, state_next;
  div_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_EXT_X;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.acc_point = 1'b1;
          if (last_point) state_next = ST_EXTENT;
        end
      end
      ST_EXTENT: begin
        cmd.cap_extent = 1'b1;
        op_next        = OP_EXT_X;
        state_next     = ST_SUM;
      end
      ST_SUM: begin
        cmd.cap_sum = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.need_div) begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (op == OP_SCALE) begin
            state_next = ST_EMIT;
          end else begin
            op_next    = div_op_t'(op + 2'd1);
            state_next = ST_LOAD;
          end
        end
      end
      ST_EMIT: begin
        done       = 1'b1;
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_done_then_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result word");

  a_plain_point_no_stall: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_point) |=> !busy)
    else $error("non-final point word stalled the block");

  a_load_only_when_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> (sts.need_div && !sts.div_done))
    else $error("divider loaded without a nonzero divisor");

endmodule

// ----- hw/rtl/bounding_box_center_and_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_center_and_scale
// Running 3D bounding box with center, uniform scale and scaled extents.
// ----------------------------------------------------------------------------
// points without the last mark are taken one per cycle, busy stays low
// a last point raises busy; the extents and centers are captured, then their
// sum, then one bit-serial divider makes four passes (x, y, z extents, scale)
// before the result word; with no points or zero extent the divider is skipped
// done is high for exactly one cycle per result word; the receiver cannot stall
// reset empties the box (min at most positive, max at most negative) and idles
module bounding_box_center_and_scale
  import bbcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  point_t  point,
  output logic    busy,
  output logic    done,
  output result_t result
);

  bbcs_cmd_t cmd;
  bbcs_sts_t sts;

  bbcs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (point.last_point),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  bbcs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .point  (point),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounding box center and scale block. Point
// words go in through the start/busy handshake with random gaps; a box model
// predicts the center, scale and scaled extents of every finished set, and
// each result word is compared field by field as it is strobed out.
// ----------------------------------------------------------------------------
module testbench
  import bbcs_pkg::*;
();

  localparam int RANDOM_POINTS  = 1100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_PRINTS     = 30;

  logic    clk;
  logic    rst;
  logic    start;
  point_t  point;
  logic    busy;
  logic    done;
  result_t result;

  bounding_box_center_and_scale u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .point  (point),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // box model state and pending results
  logic signed [COORD_WIDTH-1:0] box_lo [3];
  logic signed [COORD_WIDTH-1:0] box_hi [3];
  result_t pending_boxes [$];

  int  error_count;
  int  points_sent;
  int  sets_sent;
  int  results_checked;
  int  saturated_seen;
  int  flat_seen;
  int  stall_cycles;
  bit  steady_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_box();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = COORD_MAX;
      box_hi[a] = COORD_MIN;
    end
  endfunction

  // fold one point into the box; on the last point queue the expected word
  function automatic void predict_box(input point_t p);
    logic signed [COORD_WIDTH-1:0] coord [3];
    logic signed [COORD_WIDTH-1:0] mid [3];
    logic [EXT_OUT_W-1:0] scaled [3];
    bit [63:0] span [3];
    bit [63:0] total;
    bit [63:0] quot;
    result_t   r;
    coord[0] = p.point_x;
    coord[1] = p.point_y;
    coord[2] = p.point_z;
    for (int a = 0; a < 3; a++) begin
      if (coord[a] < box_lo[a]) box_lo[a] = coord[a];
      if (coord[a] > box_hi[a]) box_hi[a] = coord[a];
    end
    if (!p.last_point) return;
    total = 0;
    for (int a = 0; a < 3; a++) begin
      span[a] = longint'(box_hi[a]) - longint'(box_lo[a]);
      mid[a]  = COORD_WIDTH'(longint'(box_lo[a]) + longint'(span[a] >> 1));
      total   = total + span[a];
    end
    if (total == 0) begin
      for (int a = 0; a < 3; a++) scaled[a] = '0;
      r.scale_factor = '1;
      r.status       = STATUS_ZERO_EXTENT;
    end else begin
      for (int a = 0; a < 3; a++) begin
        quot = ((64'd9 * span[a]) << FRAC_BITS) / total;
        scaled[a] = (quot > 64'hFFFFF) ? '1 : EXT_OUT_W'(quot);
      end
      quot = (64'd9 << (2 * FRAC_BITS)) / total;
      r.scale_factor = (quot > 64'hFFFF_FFFF) ? '1 : SCALE_W'(quot);
      r.status       = STATUS_OK;
    end
    r.center_x        = mid[0];
    r.center_y        = mid[1];
    r.center_z        = mid[2];
    r.scaled_extent_x = scaled[0];
    r.scaled_extent_y = scaled[1];
    r.scaled_extent_z = scaled[2];
    pending_boxes.insert(pending_boxes.size(), r);
    clear_box();
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // hold start with the word until the block takes it, with random gaps before
  task automatic send_point(input point_t p);
    while (!steady_run && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_box(p);
    points_sent++;
    if (p.last_point) sets_sent++;
  endtask

  task automatic send_xyz(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z, input logic last);
    point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    send_point(p);
  endtask

  // sets whose points all coincide
  task automatic test_zero_extent();
    send_xyz(32'sh0001_8000, -32'sh0002_4000, 32'sh0000_0001, 1'b1);
    send_xyz(32'sh1234_5678, 32'sh1234_5678, -32'sd7, 1'b0);
    send_xyz(32'sh1234_5678, 32'sh1234_5678, -32'sd7, 1'b1);
    send_xyz(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_xyz(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
  endtask

  // total extents around nine lsbs, where the scale leaves its range
  task automatic test_tiny_extent();
    send_xyz(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_xyz(32'sd1, 32'sd0, 32'sd0, 1'b1);
    send_xyz(-32'sd4, 32'sd2, 32'sd0, 1'b0);
    send_xyz(32'sd0, 32'sd0, 32'sd4, 1'b1);
    send_xyz(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_xyz(32'sd3, 32'sd3, 32'sd3, 1'b1);
    send_xyz(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_xyz(32'sd4, 32'sd3, 32'sd3, 1'b1);
  endtask

  // extents spanning the whole coordinate range
  task automatic test_full_range();
    send_xyz(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_xyz(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_xyz(COORD_MAX, 32'sd0, -32'sd1, 1'b0);
    send_xyz(COORD_MIN, 32'sd0, -32'sd1, 1'b1);
  endtask

  // odd extents below zero, center rounds toward the minimum
  task automatic test_center_rounding();
    send_xyz(-32'sd3, -32'sd5, -32'sd1, 1'b0);
    send_xyz(32'sd0, -32'sd2, 32'sd0, 1'b1);
  endtask

  function automatic logic signed [31:0] random_coord(input logic signed [31:0] base,
                                                      input int spread, input bit wild);
    if (wild) begin
      case ($urandom_range(0, 5))
        0: return COORD_MIN;
        1: return COORD_MAX;
        2: return $urandom;
        default: ;
      endcase
    end
    return (spread == 0) ? base : base + 32'($urandom >> (32 - spread));
  endfunction

  task automatic test_random_sets();
    int  n_sent;
    int  set_len;
    bit  wild;
    bit  tight;
    int  spread [3];
    logic signed [31:0] base [3];
    point_t p;
    n_sent = 0;
    while (n_sent < RANDOM_POINTS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      wild    = ($urandom_range(0, 7) == 0);
      tight   = ($urandom_range(0, 5) == 0);
      for (int a = 0; a < 3; a++) begin
        base[a] = $urandom;
        if (tight) spread[a] = $urandom_range(0, 3);
        else spread[a] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32);
      end
      for (int i = 0; i < set_len; i++) begin
        p.point_x    = random_coord(base[0], spread[0], wild);
        p.point_y    = random_coord(base[1], spread[1], wild);
        p.point_z    = random_coord(base[2], spread[2], wild);
        p.last_point = (i == set_len - 1);
        // one long stretch without sender gaps
        steady_run = (n_sent >= 400 && n_sent < 600);
        send_point(p);
        n_sent++;
      end
    end
    steady_run = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_boxes.pop_front();
        compare_field("center_x", result.center_x, want.center_x);
        compare_field("center_y", result.center_y, want.center_y);
        compare_field("center_z", result.center_z, want.center_z);
        compare_field("scaled_extent_x", result.scaled_extent_x, want.scaled_extent_x);
        compare_field("scaled_extent_y", result.scaled_extent_y, want.scaled_extent_y);
        compare_field("scaled_extent_z", result.scaled_extent_z, want.scaled_extent_z);
        compare_field("scale_factor", result.scale_factor, want.scale_factor);
        compare_field("status", result.status, want.status);
        results_checked++;
        if (want.status == STATUS_ZERO_EXTENT) flat_seen++;
        else if (want.scale_factor == '1) saturated_seen++;
      end
    end
  end

  // a word taken or a result strobed counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    point <= '0;
    steady_run = 1'b0;
    clear_box();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_zero_extent();
    test_tiny_extent();
    test_full_range();
    test_center_rounding();
    test_random_sets();
    start <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d points in %0d sets, %0d result words checked",
             points_sent, sets_sent, results_checked);
    $display("of those, %0d flat boxes and %0d with the scale pinned at full range",
             flat_seen, saturated_seen);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bbcs_pkg.sv
hw/rtl/bbcs_div.sv
hw/rtl/bbcs_dp.sv
hw/rtl/bbcs_ctrl.sv
hw/rtl/bounding_box_center_and_scale.sv
dv/testbench.sv
